// ----- hdl/sdf_pkg.sv -----
// Shared constants and codes for the support disjointness filter.
// No dependencies; imported by the top level.
package sdf_pkg;

   localparam int unsigned MAX_SIDE_DEFAULT   = 12;
   localparam int unsigned MASK_WORDS_DEFAULT = 28;
   localparam int unsigned SIDE_RESET         = 9;

   localparam int unsigned SIDE_W  = 4;
   localparam int unsigned LEVEL_W = 8;
   localparam int unsigned COUNT_W = 32;

   // Each mask word holds 64 cells: low cell bits select the bit, the rest the word.
   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned BIT_SEL_W = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic {
      KIND_QUERY     = 1'b0,
      KIND_CATALOGUE = 1'b1
   } kind_type;

endpackage

// ----- hdl/support_disjointness_filter.sv -----
// Top level of the support disjointness filter: input register, cell test/set
// against the query mask, and the result register. Uses sdf_pkg.
//
// One record byte per transaction, one transaction per cycle sustained while
// the result side does not stall. A byte is held in the input register, where
// the cell index, the query mask lookup and the record flags are resolved, and
// the last byte of a catalogue record loads the result register when it leaves
// the input register. The query mask lives in flip-flops (MASK_WORDS words of
// 64 bits) and is cleared in the same cycle as the first byte of a query, so
// back-to-back queries and catalogue records need no gaps. Side values below 2
// act as 2 and above MAX_SIDE as MAX_SIDE; writing the side register restarts
// record framing but keeps the mask and the pool count.
module support_disjointness_filter
   import sdf_pkg::*;
#(
   parameter int unsigned MAX_SIDE   = MAX_SIDE_DEFAULT,
   parameter int unsigned MASK_WORDS = MASK_WORDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_write_enable,
   input  logic [SIDE_W-1:0]  csr_write_data,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [LEVEL_W-1:0] req_level,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_keep,
   output logic               rsp_malformed,
   output logic [COUNT_W-1:0] rsp_pool_count
);

   localparam int unsigned N_W    = $clog2(MAX_SIDE + 1);
   localparam int unsigned POS_W  = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int unsigned RB_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
   localparam int unsigned CELL_W =
      $clog2((MAX_SIDE * MAX_SIDE - 1) * MAX_SIDE + (1 << LEVEL_W));
   localparam int unsigned WORD_W = CELL_W - BIT_SEL_W;
   localparam int unsigned IDX_W  = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

   localparam logic [N_W-1:0] SIDE_MIN = N_W'(2);
   localparam logic [N_W-1:0] SIDE_MAX = N_W'(MAX_SIDE);
   localparam logic [N_W-1:0] SIDE_RST =
      (SIDE_RESET < 2) ? SIDE_MIN :
      (SIDE_RESET > MAX_SIDE) ? SIDE_MAX : N_W'(SIDE_RESET);
   localparam logic [POS_W-1:0] LAST_RST =
      POS_W'(int'(SIDE_RST) * int'(SIDE_RST) - 1);

   // side in use and index of the last byte of a record
   logic [N_W-1:0]   side_ff;
   logic [POS_W-1:0] last_pos_ff;
   logic [N_W-1:0]   side_in;
   logic [RB_W-1:0]  rb_in;

   logic [POS_W-1:0] pos_ff;
   logic             bad_ff;
   logic             hit_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [WORD_BITS-1:0] mask_ff [MASK_WORDS];

   // input register
   logic               s1_valid_ff;
   kind_type           s1_kind_ff;
   logic [LEVEL_W-1:0] s1_level_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_keep_ff;
   logic               rsp_malformed_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic               advance;
   logic               req_take;
   logic [POS_W-1:0]   pos_use;
   logic               first;
   logic               last;
   logic [CELL_W-1:0]  cell_idx;
   logic [WORD_W-1:0]  word;
   logic [IDX_W-1:0]   idx;
   logic [BIT_SEL_W-1:0] bit_sel;
   logic               usable;
   logic               is_query;
   logic               clear_query;
   logic               bad_in;
   logic               hit_in;
   logic               keep_in;
   logic               emit;
   logic [COUNT_W-1:0] count_base;
   logic [COUNT_W-1:0] count_in;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // clamp the written side and precompute the record length
   always_comb begin
      side_in = N_W'(csr_write_data);
      if (N_W'(csr_write_data) < SIDE_MIN) begin
         side_in = SIDE_MIN;
      end else if ({1'b0, csr_write_data} > (SIDE_W + 1)'(MAX_SIDE)) begin
         side_in = SIDE_MAX;
      end
      rb_in = RB_W'(side_in) * RB_W'(side_in);
   end

   always_comb begin
      pos_use     = (pos_ff > last_pos_ff) ? last_pos_ff : pos_ff;
      first       = (pos_use == '0);
      last        = (pos_use == last_pos_ff);
      is_query    = (s1_kind_ff == KIND_QUERY);
      clear_query = first && is_query;

      cell_idx = CELL_W'(pos_use) * CELL_W'(side_ff) + CELL_W'(s1_level_ff);
      word     = cell_idx[CELL_W-1:BIT_SEL_W];
      bit_sel  = cell_idx[BIT_SEL_W-1:0];
      usable   = ({{(32 - LEVEL_W){1'b0}}, s1_level_ff} < 32'(side_ff))
              && (32'(word) < MASK_WORDS);
      idx      = usable ? IDX_W'(word) : '0;

      bad_in = (!first && bad_ff) || (!is_query && !usable);
      hit_in = (!first && hit_ff) || (!is_query && usable && mask_ff[idx][bit_sel]);

      keep_in    = !bad_in && !hit_in;
      emit       = last && !is_query;
      count_base = clear_query ? '0 : count_ff;
      count_in   = count_base;
      if (emit && keep_in && count_base != COUNT_MAX) begin
         count_in = count_base + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff     <= SIDE_RST;
         last_pos_ff <= LAST_RST;
         pos_ff      <= '0;
         bad_ff      <= 1'b0;
         hit_ff      <= 1'b0;
         count_ff    <= '0;
      end else if (csr_write_enable) begin
         // restart framing; mask and count stay
         side_ff     <= side_in;
         last_pos_ff <= POS_W'(rb_in - RB_W'(1));
         pos_ff      <= '0;
         bad_ff      <= 1'b0;
         hit_ff      <= 1'b0;
      end else if (advance) begin
         pos_ff   <= last ? '0 : pos_use + POS_W'(1);
         bad_ff   <= bad_in;
         hit_ff   <= hit_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < MASK_WORDS; w++) begin
            mask_ff[w] <= '0;
         end
      end else if (advance && is_query) begin
         for (int w = 0; w < MASK_WORDS; w++) begin
            if (usable && idx == IDX_W'(w)) begin
               mask_ff[w] <= (clear_query ? '0 : mask_ff[w])
                           | (WORD_BITS'(1) << bit_sel);
            end else if (clear_query) begin
               mask_ff[w] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff  <= kind_type'(req_kind);
         s1_level_ff <= req_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_keep_ff      <= keep_in;
         rsp_malformed_ff <= bad_in;
         rsp_count_ff     <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_keep       = rsp_keep_ff;
   assign rsp_malformed  = rsp_malformed_ff;
   assign rsp_pool_count = rsp_count_ff;

endmodule

// ----- sim/tb.sv -----
// Testbench for the support disjointness filter: streams query and catalogue
// records under random gaps and stalls and checks every verdict in order.
// Depends on sdf_pkg and support_disjointness_filter.

import sdf_pkg::*;

typedef struct {
   logic               keep;
   logic               malformed;
   logic [COUNT_W-1:0] pool_count;
} verdict_type;

// Tracks the query mask and record framing, and holds the verdicts still due.
class filter_scoreboard;
   logic [WORD_BITS-1:0] cell_mask [MASK_WORDS_DEFAULT];
   logic [SIDE_W-1:0]    side_reg;
   int unsigned          byte_pos;
   bit                   rec_bad;
   bit                   rec_hit;
   logic [COUNT_W-1:0]   kept;
   verdict_type          verdicts [$];
   int                   errors;

   function new();
      foreach (cell_mask[i]) cell_mask[i] = '0;
      side_reg = SIDE_W'(SIDE_RESET);
      byte_pos = 0;
      rec_bad  = 1'b0;
      rec_hit  = 1'b0;
      kept     = '0;
      errors   = 0;
   endfunction

   function int unsigned side_used();
      int unsigned n;
      n = side_reg;
      if (n < 2) n = 2;
      if (n > MAX_SIDE_DEFAULT) n = MAX_SIDE_DEFAULT;
      return n;
   endfunction

   // Restart framing; keep the mask and the count.
   function void write_side(logic [SIDE_W-1:0] value);
      side_reg = value;
      byte_pos = 0;
      rec_bad  = 1'b0;
      rec_hit  = 1'b0;
   endfunction

   function void note_byte(kind_type kind, logic [LEVEL_W-1:0] level);
      int unsigned n, rec_len, pos, cell_no, word;
      bit          usable;
      verdict_type v;
      n       = side_used();
      rec_len = n * n;
      pos     = byte_pos;
      if (pos >= rec_len) pos = rec_len - 1;
      if (pos == 0) begin
         rec_bad = 1'b0;
         rec_hit = 1'b0;
         if (kind == KIND_QUERY) begin
            foreach (cell_mask[i]) cell_mask[i] = '0;
            kept = '0;
         end
      end
      cell_no = pos * n + level;
      word    = cell_no >> BIT_SEL_W;
      usable  = (level < n) && (word < MASK_WORDS_DEFAULT);
      if (kind == KIND_QUERY) begin
         if (usable) cell_mask[word][cell_no[BIT_SEL_W-1:0]] = 1'b1;
      end else if (!usable) begin
         rec_bad = 1'b1;
      end else if (cell_mask[word][cell_no[BIT_SEL_W-1:0]]) begin
         rec_hit = 1'b1;
      end
      if (pos + 1 >= rec_len) begin
         byte_pos = 0;
         if (kind == KIND_CATALOGUE) begin
            v.keep = !rec_bad && !rec_hit;
            if (v.keep && kept != COUNT_MAX) kept = kept + 1;
            v.malformed  = rec_bad;
            v.pool_count = kept;
            verdicts.push_back(v);
         end
      end else begin
         byte_pos = pos + 1;
      end
   endfunction

   function void check_verdict(logic keep, logic malformed, logic [COUNT_W-1:0] pool_count);
      verdict_type v;
      if (verdicts.size() == 0) begin
         $error("verdict arrived with none pending: keep %0d malformed %0d pool_count %0d",
                keep, malformed, pool_count);
         errors++;
         return;
      end
      v = verdicts.pop_front();
      if (keep !== v.keep) begin
         $error("keep: expected %0d, actual %0d", v.keep, keep);
         errors++;
      end
      if (malformed !== v.malformed) begin
         $error("malformed: expected %0d, actual %0d", v.malformed, malformed);
         errors++;
      end
      if (pool_count !== v.pool_count) begin
         $error("pool_count: expected %0d, actual %0d", v.pool_count, pool_count);
         errors++;
      end
   endfunction

   function int pending();
      return verdicts.size();
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_CYCLES = 6;
   localparam int HOLD_CYCLES = 250;
   localparam int NUM_PHASES  = 11;

   typedef enum int {
      REC_QUERY,
      REC_DISJOINT,
      REC_RANDOM,
      REC_BAD,
      REC_MIXED,
      REC_NOISE
   } record_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [SIDE_W-1:0]  csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = 1'b0;
   logic [LEVEL_W-1:0] req_level = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_keep;
   logic               rsp_malformed;
   logic [COUNT_W-1:0] rsp_pool_count;

   filter_scoreboard sb;
   int   cycle_count = 0;
   bit   calm = 1'b0;
   int   hold_ticket = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   stall_left = 0;
   int   query_level [MAX_SIDE_DEFAULT * MAX_SIDE_DEFAULT];

   logic [8:0] directed [24] = '{
      // catalogue before any query
      {KIND_CATALOGUE, 8'd0}, {KIND_CATALOGUE, 8'd1},
      {KIND_CATALOGUE, 8'd1}, {KIND_CATALOGUE, 8'd0},
      // query with levels too large
      {KIND_QUERY, 8'd0}, {KIND_QUERY, 8'd1}, {KIND_QUERY, 8'd255}, {KIND_QUERY, 8'd2},
      // disjoint, hitting, malformed
      {KIND_CATALOGUE, 8'd1}, {KIND_CATALOGUE, 8'd0},
      {KIND_CATALOGUE, 8'd0}, {KIND_CATALOGUE, 8'd1},
      {KIND_CATALOGUE, 8'd0}, {KIND_CATALOGUE, 8'd0},
      {KIND_CATALOGUE, 8'd1}, {KIND_CATALOGUE, 8'd1},
      {KIND_CATALOGUE, 8'd1}, {KIND_CATALOGUE, 8'd0},
      {KIND_CATALOGUE, 8'd1}, {KIND_CATALOGUE, 8'd255},
      // mixed kinds: catalogue first, then query first ending on a query byte
      {KIND_CATALOGUE, 8'd1}, {KIND_QUERY, 8'd0}, {KIND_QUERY, 8'd1}, {KIND_CATALOGUE, 8'd0}
   };
   logic [8:0] mixed_tail [4] = '{
      {KIND_QUERY, 8'd1}, {KIND_CATALOGUE, 8'd0}, {KIND_CATALOGUE, 8'd1}, {KIND_QUERY, 8'd0}
   };

   logic [SIDE_W-1:0] phase_side [NUM_PHASES] = '{
      4'd2, 4'd3, 4'd0, 4'd9, 4'd4, 4'd12, 4'd15, 4'd1, 4'd5, 4'd3, 4'd2
   };
   int phase_budget [NUM_PHASES] = '{45, 45, 45, 162, 45, 288, 144, 45, 45, 45, 45};

   support_disjointness_filter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_level        (req_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_keep         (rsp_keep),
      .rsp_malformed    (rsp_malformed),
      .rsp_pool_count   (rsp_pool_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned bad_level(int unsigned n);
      case ($urandom_range(0, 2))
         0: return n;
         1: return 255;
         default: return $urandom_range(n, 255);
      endcase
   endfunction

   // Result side: check each accepted verdict, then pick the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_verdict(rsp_keep, rsp_malformed, rsp_pool_count);
         if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm) stall_left = pick_idle();
         end
      end
   end

   task automatic send_byte(input kind_type kind, input logic [LEVEL_W-1:0] level);
      int unsigned gap;
      gap = calm ? 0 : pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_level <= level;
      do @(posedge clock); while (req_stall);
      sb.note_byte(kind, level);
   endtask

   // Drop valid, drain every pending verdict and let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_side(input logic [SIDE_W-1:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.write_side(value);
   endtask

   task automatic send_record(input record_style_type style, input int unsigned n,
                              input int unsigned count);
      int unsigned pos, bad_pos, level;
      kind_type    kind;
      bad_pos = $urandom_range(0, count - 1);
      for (pos = 0; pos < count; pos++) begin
         kind  = KIND_CATALOGUE;
         level = $urandom_range(0, n - 1);
         case (style)
            REC_QUERY: begin
               kind = KIND_QUERY;
               if ($urandom_range(0, 7) == 0) level = bad_level(n);
               query_level[pos] = level;
            end
            REC_DISJOINT: begin
               // step off the query's level at this position
               if (query_level[pos] < n)
                  level = (query_level[pos] + $urandom_range(1, n - 1)) % n;
            end
            REC_BAD: begin
               if (pos == bad_pos) level = bad_level(n);
            end
            REC_MIXED: begin
               kind = kind_type'($urandom_range(0, 1));
               if ($urandom_range(0, 7) == 0) level = bad_level(n);
            end
            REC_NOISE: begin
               kind  = kind_type'($urandom_range(0, 1));
               level = $urandom_range(0, 255);
            end
            default: ;
         endcase
         send_byte(kind, LEVEL_W'(level));
      end
   endtask

   task automatic run_phase(input logic [SIDE_W-1:0] side_value, input int budget,
                            input bit catalogue_only);
      int unsigned n, rec_len, r;
      int          sent;
      bit          have_query;
      write_side(side_value);
      n          = sb.side_used();
      rec_len    = n * n;
      have_query = catalogue_only;
      sent       = 0;
      while (sent < budget) begin
         r = $urandom_range(0, 99);
         if (!have_query || (!catalogue_only && r < 15)) begin
            send_record(REC_QUERY, n, rec_len);
            have_query = 1'b1;
         end else if (r < 50) begin
            send_record(REC_DISJOINT, n, rec_len);
         end else if (r < 70) begin
            send_record(REC_RANDOM, n, rec_len);
         end else if (r < 85) begin
            send_record(REC_BAD, n, rec_len);
         end else if (r < 95) begin
            send_record(REC_MIXED, n, rec_len);
         end else begin
            send_record(REC_NOISE, n, rec_len);
         end
         sent += rec_len;
      end
      // leave a broken record behind for the next side write to cut off
      if (!catalogue_only && $urandom_range(0, 1))
         send_record(REC_NOISE, n, $urandom_range(1, rec_len - 1));
   endtask

   initial begin
      sb = new();
      foreach (query_level[i]) query_level[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_side(4'd2);
      foreach (directed[i]) send_byte(kind_type'(directed[i][8]), directed[i][7:0]);
      foreach (mixed_tail[i]) send_byte(kind_type'(mixed_tail[i][8]), mixed_tail[i][7:0]);

      for (int p = 0; p < NUM_PHASES; p++) begin
         calm = (p % 4 == 2);
         // drain first, then hold the result side off while the sender keeps going
         if (p == 0) begin
            wait_idle();
            hold_ticket = hold_ticket + 1;
         end
         run_phase(phase_side[p], phase_budget[p], phase_side[p] == 4'd15);
      end

      calm = 1'b0;
      wait_idle();
      repeat (IDLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/sdf_pkg.sv
hdl/support_disjointness_filter.sv
sim/tb.sv
